// ----- design/lzpd_pkg.sv -----
// Package for the LZP stream decoder: shared constants, register indexes,
// status codes and token phase codes. No dependencies.
`default_nettype none
package lzpd_pkg;

   localparam int HASH_BITS_DEFAULT    = 16;
   localparam int HISTORY_BITS_DEFAULT = 16;
   localparam int EPOCH_BITS           = 4;

   localparam int POS_W        = 17;
   localparam int CHUNK_BYTES  = 8;
   localparam int CSR_DATA_W   = 17;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [31:0] PRIME_MUL       = 32'd123456791;
   localparam logic [7:0]  TOKEN_ESCAPE    = 8'd255;
   localparam logic [7:0]  LEN_CONTINUE    = 8'd254;
   localparam logic [7:0]  MIN_MATCH_FLOOR = 8'd32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_MIN_MATCH  = 2'd0;
   localparam csr_index_type CSR_HASH_BITS  = 2'd1;
   localparam csr_index_type CSR_OUT_LENGTH = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_FINISHED = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   typedef logic [1:0] phase_type;
   localparam phase_type PHASE_LITERAL  = 2'd0;
   localparam phase_type PHASE_ESCAPE   = 2'd1;
   localparam phase_type PHASE_CONTINUE = 2'd2;

endpackage
`default_nettype wire

// ----- design/lzp_decoder_unit.sv -----
// LZP stream decoder top level: sequencer, chunk assembly and output register.
// Uses lzpd_pkg, lzpd_hash, lzpd_pos_table and lzpd_hist_mem.
// A raw byte goes from S_DECIDE straight to S_FINAL; a literal passes S_HASH_RD and S_HASH_WR;
// a match copies each byte by a history read in S_COPY_RD, then a write back in S_COPY_WR,
// and flushes each full chunk in S_FLUSH, which waits until the output register is free.
// Reset is synchronous; after reset, and on every 2**EPOCH_BITS-th stream start,
// the position table is swept while no request is taken.
`default_nettype none
module lzp_decoder_unit #(
   parameter int HASH_BITS    = lzpd_pkg::HASH_BITS_DEFAULT,
   parameter int HISTORY_BITS = lzpd_pkg::HISTORY_BITS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [7:0]                     req_data_byte,
   input  wire logic                           req_stream_start,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [7:0]                     rsp_byte_0,
   output logic      [7:0]                     rsp_byte_1,
   output logic      [7:0]                     rsp_byte_2,
   output logic      [7:0]                     rsp_byte_3,
   output logic      [7:0]                     rsp_byte_4,
   output logic      [7:0]                     rsp_byte_5,
   output logic      [7:0]                     rsp_byte_6,
   output logic      [7:0]                     rsp_byte_7,
   output logic      [3:0]                     rsp_byte_count,
   output logic                                rsp_last_of_run,
   output lzpd_pkg::status_type                rsp_status,
   input  wire logic                           csr_we,
   input  wire lzpd_pkg::csr_index_type        csr_index,
   input  wire logic [lzpd_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lzpd_pkg::*;

   localparam int TBL_W = EPOCH_BITS + HISTORY_BITS;

   // Sequencer state codes.
   localparam logic [3:0] S_SWEEP   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DECIDE  = 4'd2;
   localparam logic [3:0] S_HASH_RD = 4'd3;
   localparam logic [3:0] S_HASH_WR = 4'd4;
   localparam logic [3:0] S_COPY_RD = 4'd5;
   localparam logic [3:0] S_COPY_WR = 4'd6;
   localparam logic [3:0] S_FLUSH   = 4'd7;
   localparam logic [3:0] S_FINAL   = 4'd8;

   // Configuration registers.
   logic [7:0]       min_match_ff;
   logic [4:0]       hash_bits_ff;
   logic [POS_W-1:0] out_length_ff;

   // Decoder state and next values.
   logic [3:0]              state_ff, state_in;
   logic [7:0]              byte_ff, byte_in;
   logic [31:0]             context_ff, context_in;
   logic [POS_W-1:0]        out_pos_ff, out_pos_in;
   phase_type               phase_ff, phase_in;
   logic [HISTORY_BITS-1:0] match_src_ff, match_src_in;
   logic [EPOCH_BITS-1:0]   epoch_ff, epoch_in;
   logic [HASH_BITS-1:0]    sweep_ff, sweep_in;
   logic                    resume_ff, resume_in;
   logic [8:0]              remain_ff, remain_in;
   logic [HASH_BITS-1:0]    idx_ff, idx_in;
   status_type              final_status_ff, final_status_in;
   logic [7:0]              chunk_ff [CHUNK_BYTES];
   logic [7:0]              chunk_in [CHUNK_BYTES];
   logic [3:0]              chunk_len_ff, chunk_len_in;
   logic                    chunk_ovf_ff, chunk_ovf_in;

   // Output register.
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff [CHUNK_BYTES];
   logic [7:0] rsp_byte_in [CHUNK_BYTES];
   logic [3:0] rsp_count_ff, rsp_count_in;
   logic       rsp_last_ff, rsp_last_in;
   status_type rsp_status_ff, rsp_status_in;

   // Datapath helpers.
   logic                    emit_en;
   logic [7:0]              emit_byte;
   logic                    load_out;
   logic                    load_last;
   status_type              load_status;
   logic                    out_free;
   logic [7:0]              min_match_eff;
   logic [HASH_BITS-1:0]    hash_idx;
   logic                    tbl_we;
   logic [HASH_BITS-1:0]    tbl_waddr;
   logic [TBL_W-1:0]        tbl_wdata;
   logic [TBL_W-1:0]        tbl_rdata;
   logic [7:0]              hist_rdata;
   logic                    hist_we;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign min_match_eff = (min_match_ff < MIN_MATCH_FLOOR) ? MIN_MATCH_FLOOR : min_match_ff;
   assign req_ready     = (state_ff == S_IDLE);

   lzpd_hash #(
      .HASH_BITS (HASH_BITS)
   ) u_hash (
      .clock         (clock),
      .context_word  (context_ff),
      .hash_bits_cfg (hash_bits_ff),
      .hash_idx      (hash_idx)
   );

   // Position table: a word whose epoch tag differs from the current stream's
   // epoch reads as position zero, which stands in for the per-stream clear.
   lzpd_pos_table #(
      .ADDR_W (HASH_BITS),
      .DATA_W (TBL_W)
   ) u_pos_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (hash_idx),
      .rd_data (tbl_rdata)
   );

   lzpd_hist_mem #(
      .HIST_AW (HISTORY_BITS)
   ) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (HISTORY_BITS'(out_pos_ff)),
      .wr_data (emit_byte),
      .rd_addr (match_src_ff),
      .rd_data (hist_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      byte_in         = byte_ff;
      context_in      = context_ff;
      out_pos_in      = out_pos_ff;
      phase_in        = phase_ff;
      match_src_in    = match_src_ff;
      epoch_in        = epoch_ff;
      sweep_in        = sweep_ff;
      resume_in       = resume_ff;
      remain_in       = remain_ff;
      idx_in          = idx_ff;
      final_status_in = final_status_ff;
      chunk_in        = chunk_ff;
      chunk_len_in    = chunk_len_ff;
      chunk_ovf_in    = chunk_ovf_ff;
      emit_en         = 1'b0;
      emit_byte       = byte_ff;
      load_out        = 1'b0;
      load_last       = 1'b0;
      load_status     = STATUS_OK;
      tbl_we          = 1'b0;
      tbl_waddr       = idx_ff;
      tbl_wdata       = {epoch_ff, HISTORY_BITS'(out_pos_ff)};

      case (state_ff)
         S_SWEEP: begin
            tbl_we    = 1'b1;
            tbl_waddr = sweep_ff;
            tbl_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in  = resume_ff ? S_DECIDE : S_IDLE;
               resume_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               byte_in         = req_data_byte;
               final_status_in = STATUS_OK;
               state_in        = S_DECIDE;
               if (req_stream_start) begin
                  context_in   = '0;
                  out_pos_in   = '0;
                  phase_in     = PHASE_LITERAL;
                  match_src_in = '0;
                  // Epoch wrap: old tags could alias the new epoch, so sweep.
                  if (epoch_ff == '1) begin
                     epoch_in  = '0;
                     sweep_in  = '0;
                     resume_in = 1'b1;
                     state_in  = S_SWEEP;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         S_DECIDE: begin
            if (out_pos_ff >= out_length_ff) begin
               final_status_in = STATUS_FINISHED;
               state_in        = S_FINAL;
            end else begin
               case (phase_ff)
                  PHASE_ESCAPE: begin
                     if (byte_ff == 8'd0) begin
                        emit_en   = 1'b1;
                        emit_byte = TOKEN_ESCAPE;
                        phase_in  = PHASE_LITERAL;
                        state_in  = S_FINAL;
                     end else begin
                        remain_in = (byte_ff == LEN_CONTINUE) ? 9'(LEN_CONTINUE)
                                  : 9'(byte_ff) + 9'(min_match_eff) - 9'd1;
                        phase_in  = (byte_ff == LEN_CONTINUE) ? PHASE_CONTINUE
                                                              : PHASE_LITERAL;
                        state_in  = S_COPY_RD;
                     end
                  end
                  PHASE_CONTINUE: begin
                     remain_in = (byte_ff == LEN_CONTINUE) ? 9'(LEN_CONTINUE)
                               : 9'(byte_ff) + 9'(min_match_eff) - 9'd1;
                     phase_in  = (byte_ff == LEN_CONTINUE) ? PHASE_CONTINUE
                                                           : PHASE_LITERAL;
                     state_in  = S_COPY_RD;
                  end
                  default: begin
                     phase_in = PHASE_LITERAL;
                     if (out_pos_ff < POS_W'(4)) begin
                        emit_en  = 1'b1;
                        state_in = S_FINAL;
                     end else begin
                        state_in = S_HASH_RD;
                     end
                  end
               endcase
            end
         end
         S_HASH_RD: begin
            // The product of the current context is registered by now.
            idx_in   = hash_idx;
            state_in = S_HASH_WR;
         end
         S_HASH_WR: begin
            if (tbl_rdata[TBL_W-1 -: EPOCH_BITS] == epoch_ff) begin
               match_src_in = tbl_rdata[HISTORY_BITS-1:0];
            end else begin
               match_src_in = '0;
            end
            tbl_we = 1'b1;
            if (byte_ff == TOKEN_ESCAPE) begin
               phase_in = PHASE_ESCAPE;
            end else begin
               emit_en = 1'b1;
            end
            state_in = S_FINAL;
         end
         S_COPY_RD: begin
            if (remain_ff == 9'd0 || out_pos_ff >= out_length_ff) begin
               state_in = S_FINAL;
            end else if (chunk_len_ff == 4'(CHUNK_BYTES)) begin
               state_in = S_FLUSH;
            end else begin
               match_src_in = match_src_ff + 1'b1;
               remain_in    = remain_ff - 9'd1;
               state_in     = S_COPY_WR;
            end
         end
         S_COPY_WR: begin
            emit_en   = 1'b1;
            emit_byte = hist_rdata;
            state_in  = S_COPY_RD;
         end
         S_FLUSH: begin
            if (out_free) begin
               load_out     = 1'b1;
               load_status  = chunk_ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
               chunk_len_in = '0;
               chunk_ovf_in = 1'b0;
               state_in     = S_COPY_RD;
            end
         end
         S_FINAL: begin
            if (out_free) begin
               load_out     = 1'b1;
               load_last    = 1'b1;
               load_status  = chunk_ovf_ff ? STATUS_OVERFLOW : final_status_ff;
               chunk_len_in = '0;
               chunk_ovf_in = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Append one decoded byte to history, context and the open chunk.
      hist_we = emit_en;
      if (emit_en) begin
         chunk_in[chunk_len_ff[2:0]] = emit_byte;
         chunk_len_in = chunk_len_ff + 4'd1;
         if ((out_pos_ff >> HISTORY_BITS) != '0) begin
            chunk_ovf_in = 1'b1;
         end
         context_in = {context_ff[23:0], emit_byte};
         out_pos_in = out_pos_ff + 1'b1;
      end
   end

   // Output register: bytes past the count are forced to zero.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_count_in  = chunk_len_ff;
         rsp_last_in   = load_last;
         rsp_status_in = load_status;
         for (int i = 0; i < CHUNK_BYTES; i++) begin
            rsp_byte_in[i] = (4'(i) < chunk_len_ff) ? chunk_ff[i] : 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_SWEEP;
         context_ff      <= '0;
         out_pos_ff      <= '0;
         phase_ff        <= PHASE_LITERAL;
         match_src_ff    <= '0;
         epoch_ff        <= '0;
         sweep_ff        <= '0;
         resume_ff       <= 1'b0;
         remain_ff       <= '0;
         final_status_ff <= STATUS_OK;
         chunk_len_ff    <= '0;
         chunk_ovf_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         context_ff      <= context_in;
         out_pos_ff      <= out_pos_in;
         phase_ff        <= phase_in;
         match_src_ff    <= match_src_in;
         epoch_ff        <= epoch_in;
         sweep_ff        <= sweep_in;
         resume_ff       <= resume_in;
         remain_ff       <= remain_in;
         final_status_ff <= final_status_in;
         chunk_len_ff    <= chunk_len_in;
         chunk_ovf_ff    <= chunk_ovf_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      byte_ff       <= byte_in;
      idx_ff        <= idx_in;
      chunk_ff      <= chunk_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Configuration registers; writes to an index past the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_match_ff  <= 8'd32;
         hash_bits_ff  <= 5'd16;
         out_length_ff <= 17'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_MATCH:  min_match_ff  <= csr_wdata[7:0];
            CSR_HASH_BITS:  hash_bits_ff  <= csr_wdata[4:0];
            CSR_OUT_LENGTH: out_length_ff <= csr_wdata[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_byte_0      = rsp_byte_ff[0];
   assign rsp_byte_1      = rsp_byte_ff[1];
   assign rsp_byte_2      = rsp_byte_ff[2];
   assign rsp_byte_3      = rsp_byte_ff[3];
   assign rsp_byte_4      = rsp_byte_ff[4];
   assign rsp_byte_5      = rsp_byte_ff[5];
   assign rsp_byte_6      = rsp_byte_ff[6];
   assign rsp_byte_7      = rsp_byte_ff[7];
   assign rsp_byte_count  = rsp_count_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;
endmodule
`default_nettype wire

// ----- design/lzpd_hist_mem.sv -----
// History buffer of decoded bytes: one write and one registered read port.
// Depends on nothing but its parameter.
`default_nettype none
module lzpd_hist_mem #(
   parameter int HIST_AW = 16
) (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [HIST_AW-1:0] wr_addr,
   input  wire logic [7:0]         wr_data,
   input  wire logic [HIST_AW-1:0] rd_addr,
   output logic      [7:0]         rd_data
);
   logic [7:0] mem [2**HIST_AW];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- design/lzpd_pos_table.sv -----
// Position table indexed by context hash; each word carries a stream epoch tag.
// One write port and one registered read port.
`default_nettype none
module lzpd_pos_table #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 20
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ----- design/lzpd_hash.sv -----
// Context hash: registered 32-bit product, then a shift to the table index.
// Uses lzpd_pkg.
`default_nettype none
module lzpd_hash #(
   parameter int HASH_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic [31:0]          context_word,
   input  wire logic [4:0]           hash_bits_cfg,
   output logic      [HASH_BITS-1:0] hash_idx
);
   import lzpd_pkg::*;

   logic [31:0] prod_ff;
   logic [4:0]  hb_eff;
   logic [5:0]  shamt;

   always_ff @(posedge clock) begin
      prod_ff <= context_word * PRIME_MUL;
   end

   always_comb begin
      if (hash_bits_cfg == 5'd0 || hash_bits_cfg > 5'(HASH_BITS)) begin
         hb_eff = 5'(HASH_BITS);
      end else begin
         hb_eff = hash_bits_cfg;
      end
      shamt    = 6'd32 - {1'b0, hb_eff};
      hash_idx = HASH_BITS'(prod_ff >> shamt);
   end
endmodule
`default_nettype wire

// ----- tb/lzp_decoder_unit_tb.sv -----
// Self-checking testbench for the LZP stream decoder lzp_decoder_unit.
// Depends on lzpd_pkg and the design. It predicts every decoded chunk and checks
// each one, while both sides of the handshake idle and stall at random.
`timescale 1ns / 100ps
`default_nettype none
module lzp_decoder_unit_tb;
   import lzpd_pkg::*;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int DRAIN_CYCLES   = 60;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } comp_byte_type;

   typedef struct packed {
      logic [7:0][7:0] bytes;
      logic [3:0]      count;
      logic            last;
      status_type      status;
   } chunk_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic        req_stream_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_byte [8];
   logic [3:0]  rsp_byte_count;
   logic        rsp_last_of_run;
   status_type  rsp_status;
   logic        csr_we = 1'b0;
   csr_index_type csr_index = CSR_MIN_MATCH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lzp_decoder_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_stream_start(req_stream_start),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_byte_0(rsp_byte[0]), .rsp_byte_1(rsp_byte[1]),
      .rsp_byte_2(rsp_byte[2]), .rsp_byte_3(rsp_byte[3]),
      .rsp_byte_4(rsp_byte[4]), .rsp_byte_5(rsp_byte[5]),
      .rsp_byte_6(rsp_byte[6]), .rsp_byte_7(rsp_byte[7]),
      .rsp_byte_count(rsp_byte_count), .rsp_last_of_run(rsp_last_of_run),
      .rsp_status(rsp_status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Requests waiting to be driven, and decoded chunks waiting to be seen.
   comp_byte_type byte_q[$];
   chunk_type     chunk_q[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;

   // Predictor state: the decoder's tables, registers and the chunk being built.
   bit [15:0]  pos_table [65536];
   bit [7:0]   hist_mem [65536];
   bit [31:0]  ctx;
   bit [16:0]  out_pos;
   phase_type  phase;
   bit [15:0]  match_src;
   bit [7:0]   cfg_min_match = 8'd32;
   bit [4:0]   cfg_hash_bits = 5'd16;
   bit [16:0]  cfg_out_length = 17'd65536;
   chunk_type  acc;
   bit         acc_ovf;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic close_chunk(input status_type st, input bit last);
      acc.last = last;
      acc.status = acc_ovf ? STATUS_OVERFLOW : st;
      chunk_q.push_back(acc);
      acc = '0;
      acc_ovf = 1'b0;
   endtask

   task automatic put_byte(input bit [7:0] b);
      if (out_pos >= cfg_out_length) return;
      if (acc.count == 4'd8) close_chunk(STATUS_OK, 1'b0);
      if (out_pos[16]) acc_ovf = 1'b1;
      hist_mem[out_pos[15:0]] = b;
      ctx = {ctx[23:0], b};
      out_pos = out_pos + 17'd1;
      acc.bytes[acc.count] = b;
      acc.count = acc.count + 4'd1;
   endtask

   // A length byte: 254 copies 254 bytes and keeps the match open, anything
   // else closes it with the rest of the length.
   task automatic copy_match(input bit [7:0] len);
      int unsigned floor_mm;
      int unsigned n;
      floor_mm = (cfg_min_match < MIN_MATCH_FLOOR) ? MIN_MATCH_FLOOR : cfg_min_match;
      if (len == LEN_CONTINUE) begin
         n = 254;
         phase = PHASE_CONTINUE;
      end else begin
         n = len + floor_mm - 1;
         phase = PHASE_LITERAL;
      end
      while (n > 0 && out_pos < cfg_out_length) begin
         put_byte(hist_mem[match_src]);
         match_src = match_src + 16'd1;
         n--;
      end
   endtask

   task automatic decode_request(input bit [7:0] b, input bit start);
      int unsigned hb;
      bit [31:0]   prod;
      bit [15:0]   h;
      acc = '0;
      acc_ovf = 1'b0;
      if (start) begin
         foreach (pos_table[i]) pos_table[i] = '0;
         ctx = '0;
         out_pos = '0;
         phase = PHASE_LITERAL;
         match_src = '0;
      end
      if (out_pos >= cfg_out_length) begin
         close_chunk(STATUS_FINISHED, 1'b1);
         return;
      end
      if (phase == PHASE_ESCAPE) begin
         if (b == 8'd0) begin
            put_byte(TOKEN_ESCAPE);
            phase = PHASE_LITERAL;
         end else begin
            copy_match(b);
         end
      end else if (phase == PHASE_CONTINUE) begin
         copy_match(b);
      end else begin
         phase = PHASE_LITERAL;
         if (out_pos < 17'd4) begin
            put_byte(b);
         end else begin
            hb = (cfg_hash_bits == 0 || cfg_hash_bits > 16) ? 16 : cfg_hash_bits;
            prod = ctx * PRIME_MUL;
            h = 16'(prod >> (32 - hb));
            match_src = pos_table[h];
            pos_table[h] = out_pos[15:0];
            if (b == TOKEN_ESCAPE) phase = PHASE_ESCAPE;
            else put_byte(b);
         end
      end
      close_chunk(STATUS_OK, 1'b1);
   endtask

   // Driver: a new request goes out only once the previous one was taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            comp_byte_type nxt;
            nxt = byte_q.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nxt.data;
            req_stream_start <= nxt.start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: predicts on every accepted request and checks every chunk.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) decode_request(req_data_byte, req_stream_start);
         if (rsp_valid && rsp_ready) begin
            if (chunk_q.size() == 0) begin
               report("unexpected chunk, byte_count", rsp_byte_count, 0);
            end else begin
               chunk_type want;
               want = chunk_q.pop_front();
               for (int i = 0; i < 8; i++)
                  if (rsp_byte[i] !== want.bytes[i])
                     report($sformatf("byte_%0d", i), rsp_byte[i], want.bytes[i]);
               if (rsp_byte_count !== want.count)
                  report("byte_count", rsp_byte_count, want.count);
               if (rsp_last_of_run !== want.last)
                  report("last_of_run", rsp_last_of_run, want.last);
               if (rsp_status !== want.status)
                  report("status", rsp_status, want.status);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_req(input bit [7:0] d, input bit s);
      byte_q.push_back('{data: d, start: s});
   endtask

   // Waits until every request is taken and every chunk seen, plus a margin
   // for a copy that may still be running.
   task automatic wait_quiet();
      do @(negedge clock); while (byte_q.size() > 0 || req_valid || chunk_q.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_registers(input bit [7:0] mm, input bit [4:0] hb, input bit [16:0] len);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_MIN_MATCH;
      csr_wdata <= CSR_DATA_W'(mm);
      @(posedge clock);
      csr_index <= CSR_HASH_BITS;
      csr_wdata <= CSR_DATA_W'(hb);
      @(posedge clock);
      csr_index <= CSR_OUT_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_min_match = mm;
      cfg_hash_bits = hb;
      cfg_out_length = len;
   endtask

   // A well-formed stream: four raw bytes, then literals, escaped 255s and
   // matches, with a little noise mixed in.
   task automatic push_stream(input int tokens);
      int r;
      int conts;
      push_req(8'($urandom), 1'b1);
      repeat (3) push_req(8'($urandom), 1'b0);
      repeat (tokens) begin
         r = $urandom_range(99);
         if (r < 45) begin
            push_req(8'($urandom_range(254)), 1'b0);
         end else if (r < 58) begin
            push_req(TOKEN_ESCAPE, 1'b0);
            push_req(8'd0, 1'b0);
         end else if (r < 95) begin
            push_req(TOKEN_ESCAPE, 1'b0);
            conts = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0;
            repeat (conts) push_req(LEN_CONTINUE, 1'b0);
            if ($urandom_range(9) == 0) push_req(8'd255, 1'b0);
            else if (conts > 0 && $urandom_range(1)) push_req(8'd0, 1'b0);
            else push_req(8'($urandom_range(1, 12)), 1'b0);
         end else begin
            push_req(8'($urandom), 1'($urandom_range(3) == 0));
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: defaults, raw header holding both extremes, literal 0 and
      // 254, escaped 255, a continued match closed by 0 and by 255, short match.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_registers(8'd32, 5'd16, 17'd65536);
      push_req(8'd0, 1'b1);
      push_req(8'd255, 1'b0);
      push_req(8'd7, 1'b0);
      push_req(8'd128, 1'b0);
      push_req(8'd0, 1'b0);
      push_req(8'd254, 1'b0);
      push_req(TOKEN_ESCAPE, 1'b0);
      push_req(8'd0, 1'b0);
      push_req(TOKEN_ESCAPE, 1'b0);
      push_req(LEN_CONTINUE, 1'b0);
      push_req(8'd0, 1'b0);
      push_req(TOKEN_ESCAPE, 1'b0);
      push_req(LEN_CONTINUE, 1'b0);
      push_req(8'd255, 1'b0);
      push_req(TOKEN_ESCAPE, 1'b0);
      push_req(8'd1, 1'b0);
      wait_quiet();

      // Short stream that finishes inside the raw header, then an empty one.
      set_registers(8'd255, 5'd1, 17'd3);
      repeat (5) push_req(8'($urandom), byte_q.size() == 0);
      wait_quiet();
      set_registers(8'd0, 5'd31, 17'd0);
      push_req(8'hA5, 1'b1);
      push_req(8'h5A, 1'b0);
      wait_quiet();

      for (int p = 0; p < 5; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               set_registers(8'd255, 5'd1, 17'd65536);
            end
            1: begin
               send_idle_pct = 67; recv_stall_pct = 0;
               set_registers(8'd33, 5'd8, 17'd200);
            end
            2: begin
               send_idle_pct = 0;  recv_stall_pct = 67;
               set_registers(8'd32, 5'd0, 17'd65536);
            end
            3: begin
               send_idle_pct = 19; recv_stall_pct = 19;
               set_registers(8'd100, 5'd20, 17'd1000);
            end
            default: begin
               send_idle_pct = 0;  recv_stall_pct = 0;
               set_registers(8'd31, 5'd16, 17'd65535);
            end
         endcase
         repeat (2) push_stream($urandom_range(5, 9));
         wait_quiet();
      end

      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
